[rtl/core/spicds_pkg.sv]
// Shared types and constants for the SPI clock divider select block.
package spicds_pkg;

	// Shared divider operand widths.
	localparam int DIVD_W = 31;
	localparam int DIVS_W = 22;

	// Register map.
	localparam int          APB_AW       = 3;
	localparam logic        REG_CLK_KHZ  = 1'b0;

	// Field widths.
	localparam int REQ_W   = 31;
	localparam int CLK_W   = 20;
	localparam int KHZ_W   = 22;
	localparam int EST_W   = 27;
	localparam int DIV_W   = 20;
	localparam int FREQ_W  = 29;
	localparam int DEN_W   = 16;

	// Search limits and estimate constants.
	localparam logic [7:0]  PRE_MIN      = 8'd2;
	localparam logic [7:0]  PRE_MAX      = 8'd254;
	localparam logic [7:0]  RATE_MAX     = 8'd255;
	localparam int          EST_SHIFT    = 7;
	localparam int          ROUND_BIAS   = 50;
	localparam int          ROUND_DIV    = 100;
	localparam int          KHZ_DIV      = 1000;
	localparam logic [3:0]  SIZE_16      = 4'hF;
	localparam logic [3:0]  SIZE_8       = 4'h7;
	localparam logic [CLK_W-1:0] CLK_KHZ_RESET = 20'd36000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KHZ,
		ST_EST,
		ST_ROUND,
		ST_PRE,
		ST_FREQ,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

[rtl/core/spicds_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
module spicds_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spicds_pkg::div_req_t req,
	output spicds_pkg::div_rsp_t rsp
);
	import spicds_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] dsr_q;
	logic [DIVS_W:0]   trial;
	logic              fit;
	logic [DIVS_W-1:0] rem_d;

	always_comb begin
		trial = {rem_q, quo_q[DIVD_W-1]};
		fit   = (trial >= {1'b0, dsr_q});
		rem_d = fit ? DIVS_W'(trial - {1'b0, dsr_q}) : trial[DIVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Operands and partial results carry no reset.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= {quo_q[DIVD_W-2:0], fit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[rtl/core/spi_clock_divider_select.sv]
// Top level of the SPI clock divider select block: sequencer, datapath and APB register.
//
// Usage: write the peripheral input clock in kHz to the APB register at address 0
// (reset value 36000). Send one request word on the s_ channel: requested bit rate,
// SPI mode and frame width. The block answers with one result word on the m_
// channel: rate factor, prescale, packed control word and achieved bit rate, with
// tuser flagging requests below 1000 Hz (these get the slowest setting).
// Every division goes through one shared restoring divider that produces one
// quotient bit per cycle. A request takes four divisions for the estimate and
// then one division per search step plus a final one; the search may walk the
// whole prescale and rate space. A slow request takes two divisions.
// s_tready is high only while the block is idle; one request is in flight at a
// time. The result holds on m_ until it is taken; a stalled receiver keeps the
// block busy and the input side stalled. Reset returns the sequencer to idle,
// drops any pending result and restores the clock register.
module spi_clock_divider_select (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [spicds_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// Request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // requested_hz[30:0], clock_mode[32:31], sixteen_bit[33]
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // serial_clock_rate[7:0], prescale[15:8],
	                              // control_word[31:16], achieved_hz[60:32]
	output logic        m_tuser   // bad_request[0]
);
	import spicds_pkg::*;

	state_t state_q, state_d;

	logic [CLK_W-1:0]  clk_khz_q;
	logic              issued_q;
	logic [REQ_W-1:0]  req_q;
	logic [1:0]        mode_q;
	logic              wide_q;
	logic [KHZ_W-1:0]  khz_q;
	logic [EST_W-1:0]  est_q;
	logic [DIV_W-1:0]  div_q;
	logic [7:0]        rate_q;
	logic [7:0]        pre_q;
	logic [FREQ_W-1:0] freq_q;
	logic              bad_q;
	logic              search_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              in_acc;
	logic              out_acc;
	logic [DIVD_W-1:0] clk_hz;
	logic [EST_W-1:0]  clk_x100;
	logic [12:0]       rate_est;
	logic [DEN_W-1:0]  den;
	logic [20:0]       pre_est;
	logic [FREQ_W-1:0] freq_new;
	logic              too_fast;
	logic [7:0]        pre_inc;
	logic [15:0]       ctrl_word;

	assign in_acc  = s_tvalid & s_tready;
	assign out_acc = m_tvalid & m_tready;

	// ---------------- APB register ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_khz_q <= CLK_KHZ_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CLK_KHZ) begin
			clk_khz_q <= pwdata[CLK_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CLK_KHZ) ? {{(32 - CLK_W){1'b0}}, clk_khz_q} : 32'd0;

	// ---------------- datapath terms ----------------
	always_comb begin
		clk_hz   = DIVD_W'(clk_khz_q) * DIVD_W'(KHZ_DIV);
		clk_x100 = EST_W'(clk_khz_q) * EST_W'(ROUND_DIV);
		// Rate estimate: truncating divide by 128.
		rate_est = div_q[DIV_W-1:EST_SHIFT];
		den      = DEN_W'(pre_q) * DEN_W'({1'b0, rate_q} + 9'd1);
		pre_est  = {div_rsp.quotient[DIV_W-1:0], 1'b0};
		freq_new = div_rsp.quotient[FREQ_W-1:0];
		too_fast = ({{(REQ_W - FREQ_W){1'b0}}, freq_new} > req_q);
		pre_inc  = pre_q + 8'd1;
	end

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc) state_d = ST_KHZ;
			ST_KHZ: begin
				if (div_rsp.done) begin
					state_d = (div_rsp.quotient[KHZ_W-1:0] == '0) ? ST_FREQ : ST_EST;
				end
			end
			ST_EST:   if (div_rsp.done) state_d = ST_ROUND;
			ST_ROUND: if (div_rsp.done) state_d = ST_PRE;
			ST_PRE:   if (div_rsp.done) state_d = ST_FREQ;
			ST_FREQ: begin
				// Stay here while the search keeps stepping.
				if (div_rsp.done && !(search_q && too_fast)) state_d = ST_OUT;
			end
			ST_OUT:   if (out_acc) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// ---------------- sequencer: outputs ----------------
	always_comb begin
		s_tready         = 1'b0;
		m_tvalid         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_KHZ: begin
				div_req.start    = !issued_q;
				div_req.dividend = DIVD_W'(req_q);
				div_req.divisor  = DIVS_W'(KHZ_DIV);
			end
			ST_EST: begin
				div_req.start    = !issued_q;
				div_req.dividend = DIVD_W'(clk_x100);
				div_req.divisor  = khz_q;
			end
			ST_ROUND: begin
				div_req.start    = !issued_q;
				div_req.dividend = DIVD_W'(est_q >> 1) + DIVD_W'(ROUND_BIAS);
				div_req.divisor  = DIVS_W'(ROUND_DIV);
			end
			ST_PRE: begin
				div_req.start    = !issued_q;
				div_req.dividend = DIVD_W'(div_q);
				div_req.divisor  = DIVS_W'(rate_est) + DIVS_W'(1);
			end
			ST_FREQ: begin
				div_req.start    = !issued_q;
				div_req.dividend = clk_hz;
				div_req.divisor  = DIVS_W'(den);
			end
			ST_OUT:  m_tvalid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Mark the division as launched; clear on completion so the next one launches.
			if (div_rsp.done) issued_q <= 1'b0;
			else if (div_req.start) issued_q <= 1'b1;
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q  <= s_tdata[30:0];
			mode_q <= s_tdata[32:31];
			wide_q <= s_tdata[33];
		end
		if (div_rsp.done) begin
			case (state_q)
				ST_KHZ: begin
					khz_q <= div_rsp.quotient[KHZ_W-1:0];
					bad_q <= (div_rsp.quotient[KHZ_W-1:0] == '0);
					// Slow request: slowest setting, no search.
					rate_q   <= RATE_MAX;
					pre_q    <= PRE_MAX;
					search_q <= 1'b0;
				end
				ST_EST:   est_q <= div_rsp.quotient[EST_W-1:0];
				ST_ROUND: div_q <= div_rsp.quotient[DIV_W-1:0];
				ST_PRE: begin
					rate_q <= (rate_est > 13'(RATE_MAX)) ? RATE_MAX : rate_est[7:0];
					if (pre_est <= 21'(PRE_MIN)) pre_q <= PRE_MIN;
					else if (pre_est >= 21'(RATE_MAX)) pre_q <= PRE_MAX;
					else pre_q <= pre_est[7:0];
					search_q <= 1'b1;
				end
				ST_FREQ: begin
					freq_q <= freq_new;
					if (search_q && too_fast) begin
						// Advance prescale; carry into rate at the top, stop when rate saturates.
						if (pre_inc >= PRE_MAX) begin
							if (rate_q >= RATE_MAX) begin
								pre_q    <= pre_inc;
								search_q <= 1'b0;
							end else begin
								rate_q <= rate_q + 8'd1;
								pre_q  <= PRE_MIN;
							end
						end else begin
							pre_q <= pre_inc;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- result word ----------------
	assign ctrl_word = {rate_q, mode_q[0], mode_q[1], 2'b00, wide_q ? SIZE_16 : SIZE_8};
	assign m_tdata   = {3'b000, freq_q, ctrl_word, pre_q, rate_q};
	assign m_tuser   = bad_q;

	spicds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

[rtl/core/spicds_chk.sv]
// Port-level checker for the SPI clock divider select block, bound to the top level.
module spicds_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [63:0]                  m_tdata,
	input logic                         m_tuser
);
	import spicds_pkg::*;

	// Hold a stalled result word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// One request in flight: never ready while a result is pending.
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while result pending");

	// Drop ready right after a request is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !m_tvalid)
		else $error("block not busy after accepting a request");

	// Slow request gives the slowest setting.
	a_bad_slowest: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[7:0] == RATE_MAX && m_tdata[15:8] == PRE_MAX)
		else $error("bad request without slowest setting");

	// Control word carries the rate factor.
	a_ctrl_rate: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:24] == m_tdata[7:0])
		else $error("control word rate mismatch");

endmodule

bind spi_clock_divider_select spicds_chk u_spicds_chk (.*);

[verif/spi_clock_divider_select_checker.sv]
`timescale 1ns / 100ps
// Checker for the SPI clock divider select block: tracks the clock register and predicts each result word.
module spi_clock_divider_select_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [spicds_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                   pwdata,
	input  logic [31:0]                   prdata,
	input  logic                          pready,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [39:0]                   s_tdata,  // requested_hz[30:0], clock_mode[32:31],
	                                                // sixteen_bit[33]
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [63:0]                   m_tdata,  // serial_clock_rate[7:0], prescale[15:8],
	                                                // control_word[31:16], achieved_hz[60:32]
	input  logic                          m_tuser,  // bad_request[0]
	output int                            mismatches,
	output int                            outstanding,
	output int                            words_checked,
	output int                            slow_words
);

	localparam logic [19:0] KHZ_AT_RESET = 20'd36000;
	localparam logic [spicds_pkg::APB_AW-1:0] KHZ_ADDR = {spicds_pkg::REG_CLK_KHZ, 2'b00};
	localparam longint unsigned PRE_FLOOR = 2;
	localparam longint unsigned PRE_CEIL  = 254;
	localparam longint unsigned RATE_CEIL = 255;
	localparam longint unsigned EST_STEP  = 128;
	localparam logic [3:0] FRAME16_CODE = 4'hF;
	localparam logic [3:0] FRAME8_CODE  = 4'h7;

	typedef struct packed {
		logic [7:0]  rate;
		logic [7:0]  prescale;
		logic [15:0] control;
		logic [28:0] bit_hz;
		logic        slow;
	} divider_setting_t;

	logic [19:0]      clk_khz = KHZ_AT_RESET;
	divider_setting_t pending_q[$];
	divider_setting_t want;
	int               n_bad = 0;
	int               n_pending = 0;
	int               n_words = 0;
	int               n_slow = 0;

	assign mismatches    = n_bad;
	assign outstanding   = n_pending;
	assign words_checked = n_words;
	assign slow_words    = n_slow;

	function automatic longint unsigned bit_clock_hz(longint unsigned khz, longint unsigned pre,
			longint unsigned rate);
		return (khz * 1000) / (pre * (rate + 1));
	endfunction

	// Rounded estimate, clamp, then walk the prescale up (carrying into the rate) until the
	// bit clock no longer runs faster than asked.
	function automatic divider_setting_t select_divider(logic [19:0] khz, logic [30:0] req,
			logic [1:0] mode, logic wide);
		longint unsigned clk_k, req_khz, est, rate, pre, hz;
		logic searching;
		divider_setting_t s;
		clk_k = khz;
		req_khz = req / 1000;
		s.slow = (req_khz == 0);
		if (s.slow) begin
			rate = RATE_CEIL;
			pre = PRE_CEIL;
		end else begin
			est = (100 * clk_k) / req_khz;
			est = (est / 2 + 50) / 100;
			rate = est / EST_STEP;
			pre = (est / (rate + 1)) * 2;
			if (rate > RATE_CEIL)
				rate = RATE_CEIL;
			if (pre <= PRE_FLOOR)
				pre = PRE_FLOOR;
			if (pre > PRE_CEIL)
				pre = PRE_CEIL;
			hz = bit_clock_hz(clk_k, pre, rate);
			searching = hz > req;
			while (searching) begin
				pre++;
				if (pre >= PRE_CEIL) begin
					// saturated rate: stop and keep the bumped prescale, which may reach 255
					if (rate >= RATE_CEIL) begin
						searching = 1'b0;
					end else begin
						rate++;
						pre = PRE_FLOOR;
					end
				end
				if (searching) begin
					hz = bit_clock_hz(clk_k, pre, rate);
					searching = hz > req;
				end
			end
		end
		hz = bit_clock_hz(clk_k, pre, rate);
		s.rate = rate[7:0];
		s.prescale = pre[7:0];
		s.control = {rate[7:0], mode[0], mode[1], 2'b00, wide ? FRAME16_CODE : FRAME8_CODE};
		s.bit_hz = hz[28:0];
		return s;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] checker: %s", $time, what);
		n_bad++;
	endtask

	task automatic compare_field(input string name, input longint unsigned got,
			input longint unsigned exp_val);
		if (got != exp_val)
			report_mismatch($sformatf("word %0d, %s: got %0d, expected %0d", n_words, name,
				got, exp_val));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_khz = KHZ_AT_RESET;
			pending_q.delete();
			n_pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				pending_q.push_back(select_divider(clk_khz, s_tdata[30:0], s_tdata[32:31],
					s_tdata[33]));
			if (m_tvalid && m_tready) begin
				if (pending_q.size() == 0) begin
					report_mismatch($sformatf("result word %0d arrived with no request waiting",
						n_words));
				end else begin
					want = pending_q.pop_front();
					compare_field("serial_clock_rate", m_tdata[7:0], want.rate);
					compare_field("prescale", m_tdata[15:8], want.prescale);
					compare_field("control_word", m_tdata[31:16], want.control);
					compare_field("achieved_hz", m_tdata[60:32], want.bit_hz);
					compare_field("bad_request", m_tuser, want.slow);
					if (want.slow)
						n_slow++;
				end
				n_words++;
			end
			if (psel && penable && pready && paddr == KHZ_ADDR) begin
				if (pwrite)
					clk_khz = pwdata[19:0];
				else
					compare_field("clock register read", prdata, {12'b0, clk_khz});
			end
			n_pending = pending_q.size();
		end
	end

endmodule

[verif/spi_clock_divider_select_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the SPI clock divider select block: clock, reset, stimulus and verdict.
module spi_clock_divider_select_tb;

	// Longest search this stimulus reaches is one prescale walk after a carry, so for
	// ~100 words this limit is plenty.
	localparam int CYCLE_LIMIT     = 8_000_000;
	// Let the block settle after the last word.
	localparam int SETTLE_CYCLES   = 64;
	localparam int IDLE_PCT        = 12;
	localparam int RANDOM_PHASES   = 5;
	localparam int WORDS_PER_PHASE = 16;
	localparam int CALM_PHASE      = 2;
	localparam logic [spicds_pkg::APB_AW-1:0] KHZ_ADDR = {spicds_pkg::REG_CLK_KHZ, 2'b00};
	localparam logic [19:0] KHZ_MAX = 20'd1000000;
	localparam logic [19:0] KHZ_MIN = 20'd1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [spicds_pkg::APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // requested_hz[30:0], clock_mode[32:31], sixteen_bit[33]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;       // serial_clock_rate[7:0], prescale[15:8],
	                            // control_word[31:16], achieved_hz[60:32]
	logic        m_tuser;       // bad_request[0]

	int          mismatches;
	int          outstanding;
	int          words_checked;
	int          slow_words;
	int unsigned cycles = 0;
	int          n_sent = 0;
	int          n_settings = 1;  // the reset value counts as the first setting
	logic        calm = 1'b0;     // high: neither side idles

	spi_clock_divider_select dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	spi_clock_divider_select_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.words_checked (words_checked),
		.slow_words    (slow_words)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a runaway search ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d result words still expected", cycles,
				outstanding);
			$display("spi_clock_divider_select_tb: FAIL");
			$finish;
		end
	end

	// Receiver: stall about one cycle in eight, never during the calm stretch.
	always @(posedge clk)
		m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

	// One APB transfer to the clock register: setup cycle, then access until pready.
	task automatic apb_access(input logic write, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= KHZ_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drop valid and hold until every expected result word has been taken.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Change the input clock only while the block is idle, then read it back.
	task automatic set_input_clock(input logic [19:0] khz);
		wait_idle();
		apb_access(1'b1, {12'b0, khz});
		apb_access(1'b0, '0);
		n_settings++;
	endtask

	// Send one request word; idle first at random, keep valid high across back-to-back words.
	task automatic send_request(input logic [30:0] req, input logic [1:0] mode, input logic wide);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, wide, mode, req};
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	// Mix slow requests, full-range values and a spread over many decades.
	function automatic logic [30:0] random_rate();
		int unsigned pick;
		logic [31:0] r;
		pick = $urandom_range(99);
		if (pick < 8)
			r = $urandom_range(999);
		else if (pick < 28)
			r = $urandom;
		else
			r = $urandom >> $urandom_range(22, 1);
		return r[30:0];
	endfunction

	initial begin
		int phase;
		int k;
		logic [19:0] khz;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset clock of 36 MHz: slow requests, the 1 kHz edge, fastest and slowest rates.
		send_request(31'd0, 2'd0, 1'b0);
		send_request(31'd999, 2'd3, 1'b1);
		send_request(31'd1000, 2'd1, 1'b0);
		send_request(31'd1999, 2'd2, 1'b1);
		send_request(31'h7FFF_FFFF, 2'd3, 1'b1);
		send_request(31'd18_000_000, 2'd0, 1'b1);   // lands exactly on prescale 2
		send_request(31'd1_000_000, 2'd1, 1'b1);
		send_request(31'd12_345, 2'd2, 1'b0);
		send_request(31'd70_000_000, 2'd1, 1'b0);   // faster than the clock allows

		// Estimate lands on prescale 254 and is still too fast: carry into the rate.
		set_input_clock(20'd25480);
		send_request(31'd100_000, 2'd0, 1'b0);
		send_request(31'd100_001, 2'd3, 1'b1);

		// Top of the clock range: the rate saturates for low requests.
		set_input_clock(KHZ_MAX);
		send_request(31'd1000, 2'd2, 1'b1);
		send_request(31'd15_000, 2'd1, 1'b0);
		send_request(31'd500_000_000, 2'd3, 1'b0);
		send_request(31'h7FFF_FFFF, 2'd0, 1'b1);
		send_request(31'd998, 2'd1, 1'b1);

		// Bottom of the clock range.
		set_input_clock(KHZ_MIN);
		send_request(31'd1000, 2'd0, 1'b1);
		send_request(31'd500, 2'd2, 1'b0);
		send_request(31'h7FFF_FFFF, 2'd1, 1'b0);

		// Zero input clock: estimate of zero and a zero bit rate.
		set_input_clock(20'd0);
		send_request(31'd5000, 2'd3, 1'b0);
		send_request(31'd0, 2'd0, 1'b1);

		// Random phases, each under its own clock; one phase runs with no idling at all.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			khz = 20'($urandom_range(KHZ_MAX, KHZ_MIN) >> $urandom_range(10));
			if (khz == 0)
				khz = KHZ_MIN;
			set_input_clock(khz);
			calm <= (phase == CALM_PHASE);
			for (k = 0; k < WORDS_PER_PHASE; k++)
				send_request(random_rate(), 2'($urandom_range(3)), 1'($urandom_range(1)));
		end

		// Drain, then give the block time to show any stray result word.
		wait_idle();
		calm <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d request words under %0d clock settings (zero, 1 kHz, 1 GHz, random).",
			n_sent, n_settings);
		$display("Compared %0d result words field by field, %0d of them requests below 1 kHz.",
			words_checked, slow_words);
		if (mismatches == 0 && outstanding == 0) begin
			$display("spi_clock_divider_select_tb: PASS");
		end else begin
			$display("spi_clock_divider_select_tb: FAIL");
		end
		$finish;
	end

endmodule
